FILE: hdl/assert_macros.svh
// assertion macros shared by the rtl files
// no dependencies; empty bodies when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CHECK_NEVER(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`define CHECK_IMPLY(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define CHECK_NEVER(lbl, clk, rst, expr, msg)
`define CHECK_IMPLY(lbl, clk, rst, ante, cons, msg)
`endif
`endif

FILE: hdl/dfre_pkg.sv
// shared types and constants of the delimited field range extractor
// no dependencies
package dfre_pkg;

  localparam int MAX_DELIM   = 4;
  localparam int DELIM_SLOTS = (MAX_DELIM < 4) ? MAX_DELIM : 4;
  localparam int CNT_W       = 16;
  localparam int BYTE_W      = 8;
  localparam int FIELD_W     = 16;
  localparam int UNIT_W      = 16;
  localparam int CHARS_W     = 32;
  localparam int DCOUNT_W    = 3;
  localparam int CFG_IDX_W   = 2;
  localparam int Q_DEPTH     = 4;
  localparam int Q_AW        = $clog2(Q_DEPTH);
  localparam int Q_CW        = $clog2(Q_DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DELIM_CHARS = 2'd0,
    REG_DELIM_COUNT = 2'd1,
    REG_FIRST_FIELD = 2'd2,
    REG_LAST_FIELD  = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [CHARS_W-1:0]  delimiter_chars;
    logic [DCOUNT_W-1:0] delimiter_count;
    logic [FIELD_W-1:0]  first_field;
    logic [FIELD_W-1:0]  last_field;
  } cfg_t;

  // work for the back end produced by one item
  typedef struct packed {
    logic              has_held;
    logic [BYTE_W-1:0] held_byte;
    logic              has_final;
    logic              final_valid;
    logic [BYTE_W-1:0] final_byte;
    logic [CNT_W-1:0]  units;
  } entry_t;

endpackage

FILE: hdl/dfre_front.sv
// front end: classifies bytes, tracks fields and the hold register, queues result work
// depends on dfre_pkg
module dfre_front import dfre_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BYTE_W-1:0] text_byte,
  input  logic              byte_present,
  input  logic              message_end,
  input  logic              q_full,
  output logic              q_push,
  output entry_t            q_entry
);

  logic [CNT_W-1:0]    field_counter, field_counter_next;
  logic [BYTE_W-1:0]   held_byte, held_byte_next;
  logic                held_valid, held_valid_next;
  logic [CNT_W-1:0]    delimiter_tally, delimiter_tally_next;
  logic                previous_was_data, previous_was_data_next;
  logic [DCOUNT_W-1:0] n_used;
  logic                delim, sel, accept;
  logic [CNT_W-1:0]    units;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    n_used = (cfg.delimiter_count > DCOUNT_W'(DELIM_SLOTS)) ?
             DCOUNT_W'(DELIM_SLOTS) : cfg.delimiter_count;
    delim = 1'b0;
    for (int i = 0; i < DELIM_SLOTS; i++) begin
      if ((DCOUNT_W'(i) < n_used) &&
          (cfg.delimiter_chars[8*i +: 8] == text_byte)) begin
        delim = 1'b1;
      end
    end
    if (delim) begin
      sel = (32'(field_counter) >= 32'(cfg.first_field)) &&
            (32'(field_counter) < 32'(cfg.last_field));
    end else begin
      sel = (32'(field_counter) >= 32'(cfg.first_field)) &&
            (32'(field_counter) <= 32'(cfg.last_field));
    end
  end

  always_comb begin
    field_counter_next     = field_counter;
    held_byte_next         = held_byte;
    held_valid_next        = held_valid;
    delimiter_tally_next   = delimiter_tally;
    previous_was_data_next = previous_was_data;
    q_entry                = '0;
    q_push                 = 1'b0;
    units                  = '0;
    if (accept) begin
      if (byte_present) begin
        if (sel) begin
          q_entry.has_held  = held_valid;
          q_entry.held_byte = held_byte;
          held_byte_next    = text_byte;
          held_valid_next   = 1'b1;
        end
        if (delim) begin
          if (field_counter < CNT_MAX) field_counter_next = field_counter + 1'b1;
          if (delimiter_tally < CNT_MAX) delimiter_tally_next = delimiter_tally + 1'b1;
          previous_was_data_next = 1'b0;
        end else begin
          previous_was_data_next = 1'b1;
        end
      end
      if (message_end) begin
        units = delimiter_tally_next;
        if (previous_was_data_next && (units < CNT_MAX)) units = units + 1'b1;
        q_entry.has_final   = 1'b1;
        q_entry.final_valid = held_valid_next;
        q_entry.final_byte  = held_valid_next ? held_byte_next : '0;
        q_entry.units       = units;
        field_counter_next     = '0;
        held_byte_next         = '0;
        held_valid_next        = 1'b0;
        delimiter_tally_next   = '0;
        previous_was_data_next = 1'b0;
      end
      q_push = q_entry.has_held || q_entry.has_final;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      field_counter     <= '0;
      held_byte         <= '0;
      held_valid        <= 1'b0;
      delimiter_tally   <= '0;
      previous_was_data <= 1'b0;
    end else begin
      field_counter     <= field_counter_next;
      held_byte         <= held_byte_next;
      held_valid        <= held_valid_next;
      delimiter_tally   <= delimiter_tally_next;
      previous_was_data <= previous_was_data_next;
    end
  end

endmodule

FILE: hdl/dfre_fifo.sv
// short queue of result work between front and back end
// depends on dfre_pkg and assert_macros.svh
`include "assert_macros.svh"
module dfre_fifo import dfre_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t wr_data,
  output logic   full,
  input  logic   pop,
  output logic   rd_valid,
  output entry_t rd_data
);

  entry_t            mem [Q_DEPTH];
  logic [Q_AW-1:0]   wr_ptr, rd_ptr;
  logic [Q_CW-1:0]   count;

  assign full     = (count == Q_CW'(Q_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + Q_CW'(push) - Q_CW'(pop);
    end
  end

  `CHECK_NEVER(a_no_push_full, clk, rst, push && full, "push into full queue")
  `CHECK_NEVER(a_no_pop_empty, clk, rst, pop && !rd_valid, "pop from empty queue")
  `CHECK_NEVER(a_count_bound, clk, rst, count > Q_CW'(Q_DEPTH), "queue count overflow")
  `CHECK_IMPLY(a_ptr_track, clk, rst, count == '0, wr_ptr == rd_ptr, "queue pointers diverged")

endmodule

FILE: hdl/dfre_back.sv
// back end: turns queued work into result items through an output register
// depends on dfre_pkg
module dfre_back import dfre_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  entry_t            q_entry,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [BYTE_W-1:0] out_byte,
  output logic              data_valid,
  output logic              result_last,
  output logic [UNIT_W-1:0] unit_count
);

  logic              phase, phase_next;
  logic              load;
  logic [BYTE_W-1:0] byte_next;
  logic              dv_next, last_next;
  logic [UNIT_W-1:0] count_next;

  assign load = !out_valid || out_ready;

  always_comb begin
    phase_next = phase;
    q_pop      = 1'b0;
    byte_next  = q_entry.final_byte;
    dv_next    = q_entry.final_valid;
    last_next  = 1'b1;
    count_next = UNIT_W'(q_entry.units);
    if (q_entry.has_held && !phase) begin
      byte_next  = q_entry.held_byte;
      dv_next    = 1'b1;
      last_next  = 1'b0;
      count_next = '0;
    end
    if (load && q_valid) begin
      if (q_entry.has_held && !phase) begin
        phase_next = q_entry.has_final;
        q_pop      = !q_entry.has_final;
      end else begin
        phase_next = 1'b0;
        q_pop      = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      phase <= phase_next;
      if (load) out_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && q_valid) begin
      out_byte    <= byte_next;
      data_valid  <= dv_next;
      result_last <= last_next;
      unit_count  <= count_next;
    end
  end

endmodule

FILE: hdl/delimited_field_range_extractor_core.sv
// delimited field range extractor: text bytes in, selected field bytes out
// holds the configuration registers; depends on dfre_pkg, dfre_front, dfre_fifo, dfre_back
//
// usage: message bytes enter on the s_ channel, one item per cycle while s_tready is high; s_tuser[0] is 1 when
// s_tdata carries a byte, s_tlast marks the last item of a message. result items leave on
// the m_ channel: m_tdata holds the byte and the unit count, m_tuser[0] says the byte is
// extracted data, m_tlast marks the final result of a message.
// the config channel writes delimiter chars, delimiter count, first and last field;
// cfg_ready is always high; the user must write only while the block is idle (not enforced).
// the front end takes one item per cycle with no bubbles; the only limit is the 4-entry
// work queue, so an input item is taken in the cycle it arrives unless the queue is full.
// a result passes through the work queue and the output register; the back end delivers one
// result per cycle while m_tready is high, so two results of one end item leave in turn.
// reset clears the field state, the queue and the output register, and restores the
// configuration defaults (space delimiter, one code, fields 0 through 0).
// when m_tready is low the output register holds, the queue fills, and s_tready drops
// once four work entries are waiting; nothing is lost or repeated.
module delimited_field_range_extractor_core import dfre_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [7:0]           s_tdata,   // text_byte
  input  logic [0:0]           s_tuser,   // byte_present
  input  logic                 s_tlast,   // message_end
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [23:0]          m_tdata,   // out_byte, unit_count
  output logic [0:0]           m_tuser,   // data_valid
  output logic                 m_tlast,   // result_last
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CHARS_W-1:0]   cfg_data
);

  cfg_t              cfg;
  logic              q_full, q_push, q_pop, q_valid;
  entry_t            q_wr, q_rd;
  logic [BYTE_W-1:0] out_byte;
  logic [UNIT_W-1:0] unit_count;
  logic              data_valid;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.delimiter_chars <= CHARS_W'(32);
      cfg.delimiter_count <= DCOUNT_W'(1);
      cfg.first_field     <= '0;
      cfg.last_field      <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_DELIM_CHARS: cfg.delimiter_chars <= cfg_data;
        REG_DELIM_COUNT: cfg.delimiter_count <= cfg_data[DCOUNT_W-1:0];
        REG_FIRST_FIELD: cfg.first_field     <= cfg_data[FIELD_W-1:0];
        REG_LAST_FIELD:  cfg.last_field      <= cfg_data[FIELD_W-1:0];
        default: ;
      endcase
    end
  end

  dfre_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .text_byte    (s_tdata),
    .byte_present (s_tuser[0]),
    .message_end  (s_tlast),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_entry      (q_wr)
  );

  dfre_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .wr_data  (q_wr),
    .full     (q_full),
    .pop      (q_pop),
    .rd_valid (q_valid),
    .rd_data  (q_rd)
  );

  dfre_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_entry     (q_rd),
    .q_pop       (q_pop),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_byte    (out_byte),
    .data_valid  (data_valid),
    .result_last (m_tlast),
    .unit_count  (unit_count)
  );

  assign m_tdata    = {unit_count, out_byte};
  assign m_tuser[0] = data_valid;

endmodule

FILE: tb/tb_delimited_field_range_extractor_core.sv
// self-checking testbench for delimited_field_range_extractor_core
// drives text items and config writes, predicts result items in place; needs dfre_pkg
`timescale 1ns / 1ps

module tb_delimited_field_range_extractor_core;
  import dfre_pkg::*;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        data_valid;
    logic        result_last;
    logic [15:0] unit_count;
  } result_t;

  typedef struct {
    logic        is_cfg;
    cfg_reg_t    reg_idx;
    logic [31:0] reg_value;
    logic [7:0]  text_byte;
    logic        byte_present;
    logic        message_end;
    logic        typed;
    result_t     want;
  } row_t;

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [7:0]           s_tdata;
  logic [0:0]           s_tuser;
  logic                 s_tlast;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [23:0]          m_tdata;
  logic [0:0]           m_tuser;
  logic                 m_tlast;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CHARS_W-1:0]   cfg_data;

  // predictor copy of configuration and message state
  logic [31:0] delim_chars;
  logic [2:0]  delim_count;
  logic [15:0] first_fld;
  logic [15:0] last_fld;
  logic [15:0] field_idx;
  logic [7:0]  hold_byte;
  logic        hold_valid;
  logic [15:0] delim_tally;
  logic        prev_data;

  result_t pending_results[$];
  row_t    directed_rows[$];
  result_t got;
  result_t want;
  int      errors;
  bit      no_idle;
  int      rx_left;

  delimited_field_range_extractor_core dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic void clear_message();
    field_idx   = '0;
    hold_byte   = '0;
    hold_valid  = 1'b0;
    delim_tally = '0;
    prev_data   = 1'b0;
  endfunction

  // selects field bytes through the hold register and counts units at message end
  function automatic int select_and_count(input logic [7:0] b, input logic present,
                                          input logic msg_end, output result_t r0,
                                          output result_t r1);
    int          n;
    int          slots;
    logic        is_delim;
    logic        sel;
    logic [15:0] units;
    result_t     fin;
    n  = 0;
    r0 = '0;
    r1 = '0;
    if (present) begin
      is_delim = 1'b0;
      slots = (delim_count > MAX_DELIM) ? MAX_DELIM : delim_count;
      if (slots > 4) slots = 4;
      for (int i = 0; i < slots; i++) begin
        if (delim_chars[8*i +: 8] == b) is_delim = 1'b1;
      end
      if (is_delim) sel = field_idx >= first_fld && field_idx < last_fld;
      else sel = field_idx >= first_fld && field_idx <= last_fld;
      if (sel) begin
        if (hold_valid) begin
          r0 = '{hold_byte, 1'b1, 1'b0, 16'd0};
          n  = 1;
        end
        hold_byte  = b;
        hold_valid = 1'b1;
      end
      if (is_delim) begin
        if (field_idx != 16'hFFFF) field_idx++;
        if (delim_tally != 16'hFFFF) delim_tally++;
        prev_data = 1'b0;
      end else begin
        prev_data = 1'b1;
      end
    end
    if (msg_end) begin
      units = delim_tally;
      if (prev_data && units != 16'hFFFF) units++;
      if (hold_valid) fin = '{hold_byte, 1'b1, 1'b1, units};
      else fin = '{8'd0, 1'b0, 1'b1, units};
      if (n == 0) r0 = fin;
      else r1 = fin;
      n++;
      clear_message();
    end
    return n;
  endfunction

  function automatic void check_field(input string what, input int unsigned exp_val,
                                      input int unsigned act_val);
    if (exp_val != act_val) begin
      $display("%0t ns: %s mismatch, expected %0h actual %0h", $time, what, exp_val,
               act_val);
      errors++;
    end
  endfunction

  function automatic row_t cfg_row(input cfg_reg_t idx, input logic [31:0] value);
    row_t r;
    r = '{1'b1, idx, value, 8'd0, 1'b0, 1'b0, 1'b0, '0};
    return r;
  endfunction

  function automatic row_t item_row(input logic [7:0] b, input logic p, input logic e);
    row_t r;
    r = '{1'b0, REG_DELIM_CHARS, 32'd0, b, p, e, 1'b0, '0};
    return r;
  endfunction

  function automatic row_t typed_row(input logic [7:0] b, input logic p, input logic e,
                                     input result_t w);
    row_t r;
    r = '{1'b0, REG_DELIM_CHARS, 32'd0, b, p, e, 1'b1, w};
    return r;
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send_item(input logic [7:0] b, input logic p, input logic e,
                           input logic typed, input result_t w);
    result_t r0;
    result_t r1;
    int      n;
    if (!no_idle && $urandom_range(0, 7) == 0) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    s_tdata  = b;
    s_tuser  = p;
    s_tlast  = e;
    s_tvalid = 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    n = select_and_count(b, p, e, r0, r1);
    if (typed) begin
      pending_results.push_back(w);
    end else begin
      if (n > 0) pending_results.push_back(r0);
      if (n > 1) pending_results.push_back(r1);
    end
    @(negedge clk);
  endtask

  // sender holds off until every expected item has arrived and the pipe is empty
  task automatic drain();
    s_tvalid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [31:0] value);
    drain();
    cfg_index = idx;
    cfg_data  = value;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_DELIM_CHARS: delim_chars = value;
      REG_DELIM_COUNT: delim_count = value[2:0];
      REG_FIRST_FIELD: first_fld = value[15:0];
      REG_LAST_FIELD:  last_fld = value[15:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [15:0] pick_field();
    case ($urandom_range(0, 9))
      0: return 16'd0;
      1: return 16'hFFFF;
      default: return 16'($urandom_range(0, 4));
    endcase
  endfunction

  // random settings; upper data bits are noise that the register ignores
  task automatic pick_config();
    logic [31:0] chars;
    case ($urandom_range(0, 3))
      0: chars = $urandom;
      1: chars = 32'h0;
      2: chars = 32'hFFFF_FFFF;
      default: chars = {8'($urandom_range(32, 47)), 8'($urandom_range(32, 47)),
                        8'($urandom_range(32, 47)), 8'($urandom_range(32, 47))};
    endcase
    write_reg(REG_DELIM_CHARS, chars);
    write_reg(REG_DELIM_COUNT, ($urandom & 32'hFFFF_FFF8) | $urandom_range(0, 7));
    write_reg(REG_FIRST_FIELD, ($urandom & 32'hFFFF_0000) | pick_field());
    write_reg(REG_LAST_FIELD, ($urandom & 32'hFFFF_0000) | pick_field());
  endtask

  // one message with random content; returns the number of items that count
  task automatic send_message(output int sent);
    int          len;
    logic [7:0]  b;
    logic        bare_end;
    len      = $urandom_range(0, 12);
    bare_end = (len == 0) || ($urandom_range(0, 3) == 0);
    sent     = 0;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 15) == 0) send_item(8'($urandom), 1'b0, 1'b0, 1'b0, '0);
      if ($urandom_range(0, 9) < 4) b = delim_chars[8*$urandom_range(0, 3) +: 8];
      else b = 8'($urandom_range(0, 255));
      send_item(b, 1'b1, !bare_end && i == len - 1, 1'b0, '0);
      sent++;
    end
    if (bare_end) begin
      send_item(8'($urandom), 1'b0, 1'b1, 1'b0, '0);
      sent++;
    end
  endtask

  always @(negedge clk) begin
    if (no_idle) begin
      m_tready = 1'b1;
    end else if (rx_left > 0) begin
      rx_left--;
    end else if ($urandom_range(0, 2) == 0) begin
      m_tready = 1'b0;
      rx_left  = $urandom_range(0, 18);
    end else begin
      m_tready = 1'b1;
      rx_left  = $urandom_range(0, 39);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got = '{m_tdata[7:0], m_tuser[0], m_tlast, m_tdata[23:8]};
      if (pending_results.size() == 0) begin
        $display("%0t ns: unexpected item, expected none actual %h", $time, got);
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("out_byte", want.out_byte, got.out_byte);
        check_field("data_valid", want.data_valid, got.data_valid);
        check_field("result_last", want.result_last, got.result_last);
        check_field("unit_count", want.unit_count, got.unit_count);
      end
    end
  end

  initial begin
    int sent;
    int budget;
    errors    = 0;
    no_idle   = 1'b0;
    rx_left   = 0;
    m_tready  = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = '0;
    s_tlast   = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_DELIM_CHARS;
    cfg_data  = '0;
    rst       = 1'b1;
    delim_chars = 32'd32;
    delim_count = 3'd1;
    first_fld   = 16'd0;
    last_fld    = 16'd0;
    clear_message();

    // defaults after reset: space delimiter, field 0 only
    directed_rows.push_back(typed_row(8'h00, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b1, 16'd0}));
    directed_rows.push_back(typed_row(8'h61, 1'b1, 1'b1, '{8'h61, 1'b1, 1'b1, 16'd1}));
    directed_rows.push_back(item_row(8'h55, 1'b0, 1'b0));
    directed_rows.push_back(item_row(8'h61, 1'b1, 1'b0));
    directed_rows.push_back(item_row(8'h62, 1'b1, 1'b0));
    directed_rows.push_back(item_row(8'h20, 1'b1, 1'b0));
    directed_rows.push_back(item_row(8'h63, 1'b1, 1'b1));
    directed_rows.push_back(item_row(8'hFF, 1'b1, 1'b0));
    directed_rows.push_back(item_row(8'h01, 1'b1, 1'b1));
    // four codes, two of them zero; fields 1 through 2
    directed_rows.push_back(cfg_row(REG_DELIM_CHARS, 32'h002C_3B00));
    directed_rows.push_back(cfg_row(REG_DELIM_COUNT, 32'd4));
    directed_rows.push_back(cfg_row(REG_FIRST_FIELD, 32'd1));
    directed_rows.push_back(cfg_row(REG_LAST_FIELD, 32'd2));
    directed_rows.push_back(item_row(8'h41, 1'b1, 1'b0));
    directed_rows.push_back(item_row(8'h00, 1'b1, 1'b0));
    directed_rows.push_back(item_row(8'h78, 1'b1, 1'b0));
    directed_rows.push_back(item_row(8'h2C, 1'b1, 1'b0));
    directed_rows.push_back(item_row(8'h79, 1'b1, 1'b0));
    directed_rows.push_back(item_row(8'h3B, 1'b1, 1'b0));
    directed_rows.push_back(item_row(8'h7A, 1'b1, 1'b1));
    // no delimiter codes in use
    directed_rows.push_back(cfg_row(REG_DELIM_COUNT, 32'd0));
    directed_rows.push_back(cfg_row(REG_FIRST_FIELD, 32'd0));
    directed_rows.push_back(cfg_row(REG_LAST_FIELD, 32'd0));
    directed_rows.push_back(item_row(8'h20, 1'b1, 1'b0));
    directed_rows.push_back(item_row(8'h71, 1'b1, 1'b1));
    // count above the slot limit, reversed range
    directed_rows.push_back(cfg_row(REG_DELIM_CHARS, 32'hFFFF_FFFF));
    directed_rows.push_back(cfg_row(REG_DELIM_COUNT, 32'd7));
    directed_rows.push_back(cfg_row(REG_FIRST_FIELD, 32'd3));
    directed_rows.push_back(cfg_row(REG_LAST_FIELD, 32'd1));
    directed_rows.push_back(item_row(8'h80, 1'b1, 1'b0));
    directed_rows.push_back(typed_row(8'hFF, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 16'd1}));
    directed_rows.push_back(typed_row(8'h7E, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 16'd1}));
    // whole range up to the top field
    directed_rows.push_back(cfg_row(REG_DELIM_CHARS, 32'h0000_0020));
    directed_rows.push_back(cfg_row(REG_DELIM_COUNT, 32'd4));
    directed_rows.push_back(cfg_row(REG_FIRST_FIELD, 32'd0));
    directed_rows.push_back(cfg_row(REG_LAST_FIELD, 32'hFFFF));
    directed_rows.push_back(item_row(8'h80, 1'b1, 1'b0));
    directed_rows.push_back(item_row(8'h20, 1'b1, 1'b0));
    directed_rows.push_back(item_row(8'h7F, 1'b1, 1'b1));

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_value);
      end else begin
        send_item(directed_rows[i].text_byte, directed_rows[i].byte_present,
                  directed_rows[i].message_end, directed_rows[i].typed,
                  directed_rows[i].want);
      end
    end

    for (int phase = 0; phase < 8; phase++) begin
      pick_config();
      budget = 0;
      while (budget < 50) begin
        send_message(sent);
        budget += sent;
        if ($urandom_range(0, 29) == 0) drain();
      end
    end

    // last stretch runs with no idling on either side
    no_idle = 1'b1;
    pick_config();
    budget = 0;
    while (budget < 50) begin
      send_message(sent);
      budget += sent;
    end

    s_tvalid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
